@@ rtl/dag_pkg.sv @@
`timescale 1ns / 1ps

package dag_pkg;

  localparam int CURVE_POINTS = 21;

  // quotient bits: integer part of the table position plus 16 fraction bits
  localparam int POS_BITS = $clog2(CURVE_POINTS - 1);
  localparam int QW = POS_BITS + 16;
  localparam int NW = QW + 32;
  localparam int RW = $clog2(CURVE_POINTS);

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_AMOUNT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_BLEND = 8'd3;

  localparam logic [1:0] MODE_INVERSE = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_SMOOTH = 2'd2;

  localparam logic [15:0] UNITY = 16'd32768;

  localparam logic [63:0] CURVE_N = 64'(CURVE_POINTS - 1);
  localparam logic [63:0] CURVE_DEN = CURVE_N * CURVE_N * CURVE_N;

  typedef logic [CURVE_POINTS-1:0][15:0] curve_rom_t;

  // 1 - smoothstep, rounded half up
  function automatic curve_rom_t build_curve_rom();
    curve_rom_t rom;
    logic [63:0] k;
    logic [63:0] num;
    logic [63:0] s;
    for (int i = 0; i < CURVE_POINTS; i++) begin
      k = 64'(i);
      num = k * k * (64'd3 * CURVE_N - 64'd2 * k);
      s = (64'd32768 * num + CURVE_DEN / 64'd2) / CURVE_DEN;
      if (s > 64'd32768) begin
        s = 64'd32768;
      end
      rom[i] = 16'(64'd32768 - s);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve_rom();

  typedef enum logic [1:0] {
    SRC_EARLY,
    SRC_INV,
    SRC_LIN,
    SRC_SMOOTH
  } gain_src_t;

  typedef struct packed {
    logic [1:0]  curve_mode;
    logic [31:0] distance_scale;
    logic [15:0] spread_amount;
    logic [15:0] spatial_blend;
  } dag_cfg_t;

  typedef struct packed {
    gain_src_t   src;
    logic [15:0] early_gain;
    logic [15:0] coef;
  } dag_side_t;

  typedef struct packed {
    logic [31:0]   rem;
    logic [QW-1:0] nq;
    logic [31:0]   den;
    dag_side_t     side;
  } div_stage_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] coef;
  } gain_item_t;

endpackage

@@ rtl/dag_if.sv @@
`timescale 1ns / 1ps

interface dag_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic [15:0] coefficient;

  modport source(output valid, distance, coefficient, input ready);
  modport sink(input valid, distance, coefficient, output ready);
endinterface

interface dag_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gain;
  logic [15:0] mixed_coefficient;

  modport source(output valid, gain, mixed_coefficient, input ready);
  modport sink(input valid, gain, mixed_coefficient, output ready);
endinterface

interface dag_cfg_if;
  import dag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/distance_attenuation_gain.sv @@
`timescale 1ns / 1ps

// Distance attenuation gain: takes one distance and coefficient transfer per clock and
// returns gain and mixed coefficient in order, at a sustained rate of one transfer per
// cycle while the result channel accepts results. The restoring divider resolves one quotient
// bit per pipeline stage for a QW-bit quotient (QW = clog2(CURVE_POINTS-1) + 16); the input
// stage, the curve table, the interpolation and the spread and blend mixes add eight more
// register stages. Back pressure on the result channel holds every stage that
// is full, and empty stages still fill, so no item is dropped or repeated. Configuration
// writes are taken at any time on the cfg channel and must only be issued while the
// pipeline is empty; register indexes outside the four defined ones are ignored.

module distance_attenuation_gain (
  input  logic   clk,
  input  logic   rst_n,
  dag_in_if.sink     in_ch,
  dag_out_if.source  out_ch,
  dag_cfg_if.sink    cfg_ch
);
  import dag_pkg::*;

  logic [1:0]  curve_mode_r;
  logic [31:0] distance_scale_r;
  logic [15:0] spread_amount_r;
  logic [15:0] spatial_blend_r;
  dag_cfg_t    cfg;

  logic        fr_valid;
  logic        fr_ready;
  div_stage_t  fr_data;
  logic        dv_valid;
  logic        dv_ready;
  div_stage_t  dv_data;
  logic        gn_valid;
  logic        gn_ready;
  gain_item_t  gn_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r <= MODE_INVERSE;
      distance_scale_r <= 32'd65536;
      spread_amount_r <= 16'd0;
      spatial_blend_r <= 16'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_CURVE_MODE:     curve_mode_r <= cfg_ch.data[1:0];
        CFG_DISTANCE_SCALE: distance_scale_r <= cfg_ch.data[31:0];
        CFG_SPREAD_AMOUNT:  spread_amount_r <= cfg_ch.data[15:0];
        CFG_SPATIAL_BLEND:  spatial_blend_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.curve_mode = curve_mode_r;
  assign cfg.distance_scale = distance_scale_r;
  assign cfg.spread_amount = spread_amount_r;
  assign cfg.spatial_blend = spatial_blend_r;

  dag_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .distance    (in_ch.distance),
    .coefficient (in_ch.coefficient),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_data    (fr_data)
  );

  dag_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  dag_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .out_valid (gn_valid),
    .out_ready (gn_ready),
    .out_data  (gn_data)
  );

  dag_mix u_mix (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (gn_valid),
    .in_ready          (gn_ready),
    .in_data           (gn_data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .gain              (out_ch.gain),
    .mixed_coefficient (out_ch.mixed_coefficient)
  );

endmodule

@@ rtl/dag_front.sv @@
`timescale 1ns / 1ps

module dag_front (
  input  logic                clk,
  input  logic                rst_n,
  input  dag_pkg::dag_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         distance,
  input  logic [15:0]         coefficient,
  output logic                out_valid,
  input  logic                out_ready,
  output dag_pkg::div_stage_t out_data
);
  import dag_pkg::*;

  logic       v_r;
  div_stage_t data_r;
  div_stage_t data_nxt;
  logic [NW-1:0] num;
  logic [31:0]   sc;

  assign sc = cfg.distance_scale;

  always_comb begin
    num = '0;
    data_nxt.den = 32'd1;
    data_nxt.side.src = SRC_EARLY;
    data_nxt.side.early_gain = UNITY;
    data_nxt.side.coef = coefficient;
    case (cfg.curve_mode)
      MODE_LINEAR: begin
        if (distance == 32'd0) begin
          data_nxt.side.early_gain = UNITY;
        end else if (distance >= sc) begin
          data_nxt.side.early_gain = 16'd0;
        end else begin
          data_nxt.side.src = SRC_LIN;
          num = NW'(distance) << 15;
          data_nxt.den = sc;
        end
      end
      MODE_SMOOTH: begin
        if (distance == 32'd0) begin
          data_nxt.side.early_gain = CURVE_ROM[0];
        end else if (distance >= sc) begin
          data_nxt.side.early_gain = CURVE_ROM[CURVE_POINTS-1];
        end else begin
          data_nxt.side.src = SRC_SMOOTH;
          num = (NW'(distance) * NW'(CURVE_POINTS - 1)) << 16;
          data_nxt.den = sc;
        end
      end
      default: begin
        if (distance <= sc) begin
          data_nxt.side.early_gain = UNITY;
        end else begin
          data_nxt.side.src = SRC_INV;
          num = NW'(sc) << 15;
          data_nxt.den = distance;
        end
      end
    endcase
    data_nxt.rem = num[NW-1:QW];
    data_nxt.nq = num[QW-1:0];
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data = data_r;

endmodule

@@ rtl/dag_div.sv @@
`timescale 1ns / 1ps

module dag_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dag_pkg::div_stage_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dag_pkg::div_stage_t out_data
);
  import dag_pkg::*;

  logic [QW-1:0] v_r;
  logic [QW:0]   en;
  div_stage_t    stg_r [QW];

  assign en[QW] = out_ready;

  for (genvar k = 0; k < QW; k++) begin : g_step
    div_stage_t prev;
    div_stage_t step_nxt;
    logic       prev_v;
    logic [32:0] trial;
    logic [32:0] diff;

    if (k == 0) begin : g_first
      assign prev = in_data;
      assign prev_v = in_valid;
    end else begin : g_rest
      assign prev = stg_r[k-1];
      assign prev_v = v_r[k-1];
    end

    assign en[k] = !v_r[k] || en[k+1];

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
      trial = {prev.rem, prev.nq[QW-1]};
      diff = trial - {1'b0, prev.den};
      step_nxt = prev;
      if (!diff[32]) begin
        step_nxt.rem = diff[31:0];
        step_nxt.nq = {prev.nq[QW-2:0], 1'b1};
      end else begin
        step_nxt.rem = trial[31:0];
        step_nxt.nq = {prev.nq[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg_r[k] <= step_nxt;
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = v_r[QW-1];
  assign out_data = stg_r[QW-1];

endmodule

@@ rtl/dag_gain.sv @@
`timescale 1ns / 1ps

module dag_gain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dag_pkg::div_stage_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dag_pkg::gain_item_t out_data
);
  import dag_pkg::*;

  typedef struct packed {
    logic        smooth;
    logic [15:0] g_pre;
    logic [15:0] e0;
    logic [15:0] diff;
    logic [15:0] frac;
    logic [15:0] coef;
  } look_t;

  typedef struct packed {
    logic        smooth;
    logic [15:0] g_pre;
    logic [15:0] e0;
    logic [31:0] prod;
    logic [15:0] coef;
  } prod_t;

  logic [2:0] v_r;
  logic [3:0] en;
  look_t      s1_r;
  look_t      s1_nxt;
  prod_t      s2_r;
  prod_t      s2_nxt;
  gain_item_t s3_r;
  gain_item_t s3_nxt;

  logic [QW-1:0] q;
  logic [QW-1:0] qs;
  logic [RW-1:0] idx;
  logic [RW-1:0] idx_up;
  logic [15:0]   e1;
  logic [32:0]   rnd;

  assign en[3] = out_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready = en[0];

  always_comb begin
    q = in_data.nq;
    qs = q >> 16;
    if (qs > QW'(CURVE_POINTS - 2)) begin
      idx = RW'(CURVE_POINTS - 2);
    end else begin
      idx = qs[RW-1:0];
    end
    idx_up = idx + RW'(1);
    e1 = CURVE_ROM[idx_up];
    s1_nxt.smooth = (in_data.side.src == SRC_SMOOTH);
    s1_nxt.e0 = CURVE_ROM[idx];
    s1_nxt.diff = CURVE_ROM[idx] - e1;
    s1_nxt.frac = q[15:0];
    s1_nxt.coef = in_data.side.coef;
    case (in_data.side.src)
      SRC_EARLY: s1_nxt.g_pre = in_data.side.early_gain;
      SRC_INV:   s1_nxt.g_pre = q[15:0];
      SRC_LIN:   s1_nxt.g_pre = UNITY - q[15:0];
      default:   s1_nxt.g_pre = CURVE_ROM[idx];
    endcase
  end

  always_comb begin
    s2_nxt.smooth = s1_r.smooth;
    s2_nxt.g_pre = s1_r.g_pre;
    s2_nxt.e0 = s1_r.e0;
    s2_nxt.prod = s1_r.diff * s1_r.frac;
    s2_nxt.coef = s1_r.coef;
  end

  always_comb begin
    rnd = 33'(s2_r.prod) + 33'd32768;
    s3_nxt.coef = s2_r.coef;
    if (s2_r.smooth) begin
      s3_nxt.gain = s2_r.e0 - rnd[31:16];
    end else begin
      s3_nxt.gain = s2_r.g_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      if (en[1]) begin
        v_r[1] <= v_r[0];
      end
      if (en[2]) begin
        v_r[2] <= v_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign out_data = s3_r;

endmodule

@@ rtl/dag_mix.sv @@
`timescale 1ns / 1ps

module dag_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  dag_pkg::dag_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  dag_pkg::gain_item_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         gain,
  output logic [15:0]         mixed_coefficient
);
  import dag_pkg::*;

  typedef struct packed {
    logic [15:0] gain;
    logic [31:0] p1;
    logic [31:0] p2;
  } mul_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [30:0] a;
  } sum_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [46:0] m1;
  } blend_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] mixed;
  } res_t;

  localparam logic [47:0] HALF_LSB = 48'h0000_2000_0000;

  logic [3:0]  v_r;
  logic [4:0]  en;
  logic [15:0] spread;
  logic [15:0] blend;
  mul_t        m1_r;
  mul_t        m1_nxt;
  sum_t        m2_r;
  sum_t        m2_nxt;
  blend_t      m3_r;
  blend_t      m3_nxt;
  res_t        m4_r;
  res_t        m4_nxt;
  logic [31:0] a_full;
  logic [47:0] acc;

  assign spread = (cfg.spread_amount > UNITY) ? UNITY : cfg.spread_amount;
  assign blend = (cfg.spatial_blend > UNITY) ? UNITY : cfg.spatial_blend;

  assign en[4] = out_ready;
  assign en[3] = !v_r[3] || en[4];
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready = en[0];

  always_comb begin
    m1_nxt.gain = in_data.gain;
    m1_nxt.p1 = in_data.coef * (UNITY - spread);
    m1_nxt.p2 = in_data.gain * spread;
  end

  always_comb begin
    a_full = m1_r.p1 + m1_r.p2;
    m2_nxt.gain = m1_r.gain;
    m2_nxt.a = a_full[30:0];
  end

  always_comb begin
    m3_nxt.gain = m2_r.gain;
    m3_nxt.m1 = m2_r.a * blend;
  end

  always_comb begin
    acc = 48'(m3_r.m1) + (48'(UNITY - blend) << 30) + HALF_LSB;
    m4_nxt.gain = m3_r.gain;
    if (acc[47:30] > 18'(UNITY)) begin
      m4_nxt.mixed = UNITY;
    end else begin
      m4_nxt.mixed = acc[45:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      if (en[1]) begin
        v_r[1] <= v_r[0];
      end
      if (en[2]) begin
        v_r[2] <= v_r[1];
      end
      if (en[3]) begin
        v_r[3] <= v_r[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1_r <= m1_nxt;
    end
    if (en[1]) begin
      m2_r <= m2_nxt;
    end
    if (en[2]) begin
      m3_r <= m3_nxt;
    end
    if (en[3]) begin
      m4_r <= m4_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign gain = m4_r.gain;
  assign mixed_coefficient = m4_r.mixed;

endmodule

@@ rtl/dag_checker.sv @@
`timescale 1ns / 1ps

module dag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] gain,
  input logic [15:0] mixed_coefficient
);
  import dag_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with the output stage empty every stage can advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (gain <= UNITY) && (mixed_coefficient <= UNITY))
    else $error("result above unity");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(gain) && $stable(mixed_coefficient))
    else $error("stalled result changed");

endmodule

bind distance_attenuation_gain dag_checker u_dag_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .gain              (out_ch.gain),
  .mixed_coefficient (out_ch.mixed_coefficient)
);
